// ===== hdl/delay_sync_rate_resampler_defines.svh =====
// Assertion macros shared by the resampler RTL.
// Needs signals named clk and rst_n in the scope of each use.
`ifndef DELAY_SYNC_RATE_RESAMPLER_DEFINES_SVH
`define DELAY_SYNC_RATE_RESAMPLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DRSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DRSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/drsr_pkg.sv =====
// Shared types, constants and the speed table of the resampler.
// No dependencies.
package drsr_pkg;

  localparam int RING_PERIODS_DEF      = 64;
  localparam int FRAMES_PER_PERIOD_DEF = 64;
  localparam int FRAME_BITS_DEF        = 32;

  localparam int OUT_FRAME_BITS = 32;
  localparam int TARGET_BITS    = 8;
  localparam int PTIME_BITS     = 20;
  localparam int FILL_BITS      = 8;
  localparam int CFG_IDX_BITS   = 2;

  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);
  localparam logic [QCNT_BITS-1:0] QCNT_FULL = QCNT_BITS'(QDEPTH);

  localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PTIME  = 2'd1;

  localparam logic [TARGET_BITS-1:0] TARGET_RST = 8'd16;
  localparam logic [PTIME_BITS-1:0]  PTIME_RST  = 20'd1333;

  typedef logic [3:0] speed_t;

  localparam speed_t SPD_E1  = 4'd0;
  localparam speed_t SPD_E2  = 4'd1;
  localparam speed_t SPD_E4  = 4'd2;
  localparam speed_t SPD_E6  = 4'd3;
  localparam speed_t SPD_E7  = 4'd4;
  localparam speed_t SPD_E8  = 4'd5;
  localparam speed_t SPD_E10 = 4'd6;
  localparam speed_t SPD_E12 = 4'd7;
  localparam speed_t SPD_E16 = 4'd8;
  localparam speed_t SPD_E32 = 4'd9;

  // Limits on error * 1000, already adjusted for truncation toward zero.
  localparam int LIM_E32 = -5001000;
  localparam int LIM_E16 = -1501000;
  localparam int LIM_E12 = -501000;
  localparam int LIM_E10 = -12000;
  localparam int LIM_E8  = 11000;
  localparam int LIM_E7  = 300000;
  localparam int LIM_E6  = 1000000;
  localparam int LIM_E4  = 3000000;
  localparam int LIM_E2  = 6000000;

  typedef struct packed {
    logic   frame_valid;
    logic   ring_empty;
    logic   last_of_period;
    speed_t speed_code;
  } desc_t;

  typedef struct packed {
    logic [OUT_FRAME_BITS-1:0] frame;
    desc_t                     desc;
  } res_t;

  function automatic logic [5:0] speed_eighths(input speed_t code);
    logic [5:0] s;
    unique case (code)
      SPD_E1:  s = 6'd1;
      SPD_E2:  s = 6'd2;
      SPD_E4:  s = 6'd4;
      SPD_E6:  s = 6'd6;
      SPD_E7:  s = 6'd7;
      SPD_E8:  s = 6'd8;
      SPD_E10: s = 6'd10;
      SPD_E12: s = 6'd12;
      SPD_E16: s = 6'd16;
      SPD_E32: s = 6'd32;
      default: s = 6'd8;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/delay_sync_rate_resampler.sv =====
// Top level of the rate-adjusting audio delay line.
// Uses drsr_pkg, drsr_front, drsr_ram, drsr_back and the assertion macro header.
//
//   Channel  Direction  Handshake            Word
//   in_      input      in_valid / in_stall  op, frame_in, downstream_fill
//   out_     output     out_valid / out_stall frame_out, flags, speed_code
//   cfg_     input      cfg_we               cfg_index, cfg_data
//
// One input word is taken per cycle while in_stall is low; a pull that starts a
// period first does the error multiply and then the speed choice.
// Each result is registered and then leaves through a four-word queue.
// Reset is synchronous; the ring itself is not cleared, as only completed
// periods are ever played.
// in_stall rises during a period start and when the queue has no room left.
`include "delay_sync_rate_resampler_defines.svh"

module delay_sync_rate_resampler #(
  parameter int RING_PERIODS      = drsr_pkg::RING_PERIODS_DEF,
  parameter int FRAMES_PER_PERIOD = drsr_pkg::FRAMES_PER_PERIOD_DEF,
  parameter int FRAME_BITS        = drsr_pkg::FRAME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [drsr_pkg::OUT_FRAME_BITS-1:0] in_frame_in,
  input  logic [drsr_pkg::FILL_BITS-1:0]      in_downstream_fill,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [drsr_pkg::OUT_FRAME_BITS-1:0] out_frame_out,
  output logic                                out_frame_valid,
  output logic                                out_ring_empty,
  output logic                                out_last_of_period,
  output logic [3:0]                          out_speed_code,
  input  logic                                cfg_we,
  input  logic [drsr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [drsr_pkg::PTIME_BITS-1:0]     cfg_data
);

  localparam int RING_WORDS = RING_PERIODS * FRAMES_PER_PERIOD;
  localparam int AW         = $clog2(RING_WORDS);

  logic [drsr_pkg::QCNT_BITS-1:0] q_count;
  logic                           push_vld;
  drsr_pkg::res_t                 push_res;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [FRAME_BITS-1:0]          ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [FRAME_BITS-1:0]          ram_rdata;

  drsr_front #(
    .RING_PERIODS     (RING_PERIODS),
    .FRAMES_PER_PERIOD(FRAMES_PER_PERIOD),
    .FRAME_BITS       (FRAME_BITS),
    .AW               (AW)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_frame_in       (in_frame_in),
    .in_downstream_fill(in_downstream_fill),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_count           (q_count),
    .push_vld          (push_vld),
    .push_res          (push_res),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata)
  );

  drsr_ram #(
    .WIDTH(FRAME_BITS),
    .DEPTH(RING_WORDS)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  drsr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .push_vld          (push_vld),
    .push_res          (push_res),
    .q_count           (q_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_out     (out_frame_out),
    .out_frame_valid   (out_frame_valid),
    .out_ring_empty    (out_ring_empty),
    .out_last_of_period(out_last_of_period),
    .out_speed_code    (out_speed_code)
  );

  `DRSR_ASSERT_IMP(a_queue_room, push_vld, q_count != drsr_pkg::QCNT_FULL, "result queue overflow")
  `DRSR_ASSERT_NXT(a_capture_word, in_valid && !in_stall && !in_op, push_vld && !push_res.desc.frame_valid && !push_res.desc.ring_empty, "capture did not give a plain result word")
  `DRSR_ASSERT_IMP(a_last_played, push_vld && push_res.desc.last_of_period, push_res.desc.frame_valid && !push_res.desc.ring_empty, "end of period without a played frame")

endmodule

// ===== hdl/drsr_ram.sv =====
// Generic simple dual-port RAM with a registered read.
// No dependencies.
module drsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/drsr_front.sv =====
// Front end: takes words, holds the ring pointers and configuration,
// picks the speed at each period start and issues ring accesses. Uses drsr_pkg.
module drsr_front #(
  parameter int RING_PERIODS      = drsr_pkg::RING_PERIODS_DEF,
  parameter int FRAMES_PER_PERIOD = drsr_pkg::FRAMES_PER_PERIOD_DEF,
  parameter int FRAME_BITS        = drsr_pkg::FRAME_BITS_DEF,
  parameter int AW                = $clog2(RING_PERIODS * FRAMES_PER_PERIOD)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [drsr_pkg::OUT_FRAME_BITS-1:0]  in_frame_in,
  input  logic [drsr_pkg::FILL_BITS-1:0]       in_downstream_fill,
  input  logic                                 cfg_we,
  input  logic [drsr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [drsr_pkg::PTIME_BITS-1:0]      cfg_data,
  input  logic [drsr_pkg::QCNT_BITS-1:0]       q_count,
  output logic                                 push_vld,
  output drsr_pkg::res_t                       push_res,
  output logic                                 ram_we,
  output logic [AW-1:0]                        ram_waddr,
  output logic [FRAME_BITS-1:0]                ram_wdata,
  output logic [AW-1:0]                        ram_raddr,
  input  logic [FRAME_BITS-1:0]                ram_rdata
);

  localparam int PW  = $clog2(RING_PERIODS);
  localparam int OW  = (FRAMES_PER_PERIOD > 1) ? $clog2(FRAMES_PER_PERIOD) : 1;
  localparam int CW  = $clog2(8 * FRAMES_PER_PERIOD + 1);
  localparam int DW  = $clog2(255 + RING_PERIODS) + 2;
  localparam int PRW = DW + drsr_pkg::PTIME_BITS + 1;
  localparam int JW  = CW + 7;
  localparam int QCW = drsr_pkg::QCNT_BITS;

  localparam logic [CW-1:0] OC_E1  = CW'((16 * FRAMES_PER_PERIOD + 1) / 2);
  localparam logic [CW-1:0] OC_E2  = CW'((16 * FRAMES_PER_PERIOD + 2) / 4);
  localparam logic [CW-1:0] OC_E4  = CW'((16 * FRAMES_PER_PERIOD + 4) / 8);
  localparam logic [CW-1:0] OC_E6  = CW'((16 * FRAMES_PER_PERIOD + 6) / 12);
  localparam logic [CW-1:0] OC_E7  = CW'((16 * FRAMES_PER_PERIOD + 7) / 14);
  localparam logic [CW-1:0] OC_E8  = CW'((16 * FRAMES_PER_PERIOD + 8) / 16);
  localparam logic [CW-1:0] OC_E10 = CW'((16 * FRAMES_PER_PERIOD + 10) / 20);
  localparam logic [CW-1:0] OC_E12 = CW'((16 * FRAMES_PER_PERIOD + 12) / 24);
  localparam logic [CW-1:0] OC_E16 = CW'((16 * FRAMES_PER_PERIOD + 16) / 32);
  localparam logic [CW-1:0] OC_E32 = CW'((16 * FRAMES_PER_PERIOD + 32) / 64);

  localparam logic signed [PRW-1:0] T_E32 = PRW'(drsr_pkg::LIM_E32);
  localparam logic signed [PRW-1:0] T_E16 = PRW'(drsr_pkg::LIM_E16);
  localparam logic signed [PRW-1:0] T_E12 = PRW'(drsr_pkg::LIM_E12);
  localparam logic signed [PRW-1:0] T_E10 = PRW'(drsr_pkg::LIM_E10);
  localparam logic signed [PRW-1:0] T_E8  = PRW'(drsr_pkg::LIM_E8);
  localparam logic signed [PRW-1:0] T_E7  = PRW'(drsr_pkg::LIM_E7);
  localparam logic signed [PRW-1:0] T_E6  = PRW'(drsr_pkg::LIM_E6);
  localparam logic signed [PRW-1:0] T_E4  = PRW'(drsr_pkg::LIM_E4);
  localparam logic signed [PRW-1:0] T_E2  = PRW'(drsr_pkg::LIM_E2);

  localparam logic [PW-1:0] LAST_PERIOD = PW'(RING_PERIODS - 1);
  localparam logic [OW-1:0] LAST_FRAME  = OW'(FRAMES_PER_PERIOD - 1);

  logic [drsr_pkg::TARGET_BITS-1:0] target_r, target_nxt;
  logic [drsr_pkg::PTIME_BITS-1:0]  ptime_r, ptime_nxt;
  logic [PW-1:0]                    cap_per_r, cap_per_nxt;
  logic [OW-1:0]                    cap_off_r, cap_off_nxt;
  logic [PW-1:0]                    play_per_r, play_per_nxt;
  logic [CW-1:0]                    out_idx_r, out_idx_nxt;
  logic [CW-1:0]                    out_cnt_r, out_cnt_nxt;
  drsr_pkg::speed_t                 speed_r, speed_nxt;
  logic                             busy_r, busy_nxt;
  logic signed [PRW-1:0]            prod_r, prod_nxt;
  logic                             s1_vld_r, s1_vld_nxt;
  drsr_pkg::desc_t                  s1_r, s1_nxt;

  logic                             accept;
  logic [PW:0]                      fill_w;
  logic signed [DW-1:0]             diff;
  drsr_pkg::speed_t                 spd_pick;
  logic [CW-1:0]                    oc_pick;
  logic [5:0]                       s_cur;
  logic [JW-1:0]                    jm;
  logic [JW-1:0]                    src_w;
  logic [OW-1:0]                    src;
  logic [CW-1:0]                    idx_inc;
  logic [AW-1:0]                    cap_base;
  logic [AW-1:0]                    play_base;
  logic [QCW:0]                     credit_sum;
  logic [FRAME_BITS+drsr_pkg::OUT_FRAME_BITS-1:0] win;
  logic [FRAME_BITS+drsr_pkg::OUT_FRAME_BITS-1:0] wout;

  function automatic logic [PW-1:0] next_period(input logic [PW-1:0] p);
    return (p == LAST_PERIOD) ? '0 : p + PW'(1);
  endfunction

  assign credit_sum = (QCW+1)'(q_count) + (QCW+1)'(s1_vld_r) + (QCW+1)'(1);
  assign in_stall   = busy_r | (credit_sum > (QCW+1)'(drsr_pkg::QDEPTH));
  assign accept     = in_valid & ~in_stall;

  assign fill_w = {1'b0, cap_per_r} - {1'b0, play_per_r}
                + ((cap_per_r < play_per_r) ? (PW+1)'(RING_PERIODS) : '0);
  assign diff   = DW'(target_r) - DW'(in_downstream_fill) - DW'(fill_w[PW-1:0]);

  always_comb begin
    if (prod_r <= T_E32) begin
      spd_pick = drsr_pkg::SPD_E32;
    end else if (prod_r <= T_E16) begin
      spd_pick = drsr_pkg::SPD_E16;
    end else if (prod_r <= T_E12) begin
      spd_pick = drsr_pkg::SPD_E12;
    end else if (prod_r <= T_E10) begin
      spd_pick = drsr_pkg::SPD_E10;
    end else if (prod_r < T_E8) begin
      spd_pick = drsr_pkg::SPD_E8;
    end else if (prod_r < T_E7) begin
      spd_pick = drsr_pkg::SPD_E7;
    end else if (prod_r < T_E6) begin
      spd_pick = drsr_pkg::SPD_E6;
    end else if (prod_r < T_E4) begin
      spd_pick = drsr_pkg::SPD_E4;
    end else if (prod_r < T_E2) begin
      spd_pick = drsr_pkg::SPD_E2;
    end else begin
      spd_pick = drsr_pkg::SPD_E1;
    end
  end

  always_comb begin
    unique case (spd_pick)
      drsr_pkg::SPD_E1:  oc_pick = OC_E1;
      drsr_pkg::SPD_E2:  oc_pick = OC_E2;
      drsr_pkg::SPD_E4:  oc_pick = OC_E4;
      drsr_pkg::SPD_E6:  oc_pick = OC_E6;
      drsr_pkg::SPD_E7:  oc_pick = OC_E7;
      drsr_pkg::SPD_E8:  oc_pick = OC_E8;
      drsr_pkg::SPD_E10: oc_pick = OC_E10;
      drsr_pkg::SPD_E12: oc_pick = OC_E12;
      drsr_pkg::SPD_E16: oc_pick = OC_E16;
      drsr_pkg::SPD_E32: oc_pick = OC_E32;
      default:           oc_pick = OC_E8;
    endcase
  end

  // Source frame for output frame out_idx_r at the current speed.
  assign s_cur = drsr_pkg::speed_eighths(speed_r);
  always_comb begin
    if (s_cur >= 6'd8) begin
      jm    = JW'(out_idx_r) * JW'(s_cur);
      src_w = jm >> 3;
    end else begin
      jm    = (JW'(out_idx_r) + JW'(1)) * JW'(s_cur) + JW'(7);
      src_w = (jm >> 3) - JW'(1);
    end
    src = (src_w > JW'(FRAMES_PER_PERIOD - 1)) ? LAST_FRAME : OW'(src_w);
  end

  assign idx_inc   = out_idx_r + CW'(1);
  assign cap_base  = AW'(cap_per_r) * AW'(FRAMES_PER_PERIOD);
  assign play_base = AW'(play_per_r) * AW'(FRAMES_PER_PERIOD);

  assign win       = {{FRAME_BITS{1'b0}}, in_frame_in};
  assign ram_wdata = win[FRAME_BITS-1:0];
  assign ram_waddr = cap_base + AW'(cap_off_r);
  assign ram_raddr = busy_r ? play_base : play_base + AW'(src);

  always_comb begin
    target_nxt   = target_r;
    ptime_nxt    = ptime_r;
    cap_per_nxt  = cap_per_r;
    cap_off_nxt  = cap_off_r;
    play_per_nxt = play_per_r;
    out_idx_nxt  = out_idx_r;
    out_cnt_nxt  = out_cnt_r;
    speed_nxt    = speed_r;
    busy_nxt     = 1'b0;
    prod_nxt     = prod_r;
    s1_vld_nxt   = 1'b0;
    s1_nxt       = '{frame_valid: 1'b0, ring_empty: 1'b0, last_of_period: 1'b0,
                     speed_code: speed_r};
    ram_we       = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        drsr_pkg::CFG_TARGET: target_nxt = cfg_data[drsr_pkg::TARGET_BITS-1:0];
        drsr_pkg::CFG_PTIME:  ptime_nxt  = cfg_data;
        default: ;
      endcase
    end

    if (busy_r) begin
      // Period start, after the error multiply: the speed follows from the product.
      speed_nxt         = spd_pick;
      s1_vld_nxt        = 1'b1;
      s1_nxt.speed_code = spd_pick;
      if (oc_pick == '0) begin
        play_per_nxt = next_period(play_per_r);
      end else begin
        s1_nxt.frame_valid = 1'b1;
        if (oc_pick == CW'(1)) begin
          s1_nxt.last_of_period = 1'b1;
          out_cnt_nxt           = '0;
          out_idx_nxt           = '0;
          play_per_nxt          = next_period(play_per_r);
        end else begin
          out_cnt_nxt = oc_pick;
          out_idx_nxt = CW'(1);
        end
      end
    end else if (accept && !in_op) begin
      ram_we     = 1'b1;
      s1_vld_nxt = 1'b1;
      if (cap_off_r == LAST_FRAME) begin
        cap_off_nxt = '0;
        cap_per_nxt = next_period(cap_per_r);
      end else begin
        cap_off_nxt = cap_off_r + OW'(1);
      end
    end else if (accept && in_op) begin
      s1_vld_nxt = 1'b1;
      if (out_cnt_r == '0) begin
        if (play_per_r == cap_per_r) begin
          s1_nxt.ring_empty = 1'b1;
        end else begin
          s1_vld_nxt = 1'b0;
          busy_nxt   = 1'b1;
          prod_nxt   = diff * $signed({1'b0, ptime_r});
        end
      end else begin
        s1_nxt.frame_valid = 1'b1;
        if (idx_inc >= out_cnt_r) begin
          s1_nxt.last_of_period = 1'b1;
          out_cnt_nxt           = '0;
          out_idx_nxt           = '0;
          play_per_nxt          = next_period(play_per_r);
        end else begin
          out_idx_nxt = idx_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= drsr_pkg::TARGET_RST;
      ptime_r    <= drsr_pkg::PTIME_RST;
      cap_per_r  <= '0;
      cap_off_r  <= '0;
      play_per_r <= '0;
      out_idx_r  <= '0;
      out_cnt_r  <= '0;
      speed_r    <= drsr_pkg::SPD_E8;
      busy_r     <= 1'b0;
      s1_vld_r   <= 1'b0;
    end else begin
      target_r   <= target_nxt;
      ptime_r    <= ptime_nxt;
      cap_per_r  <= cap_per_nxt;
      cap_off_r  <= cap_off_nxt;
      play_per_r <= play_per_nxt;
      out_idx_r  <= out_idx_nxt;
      out_cnt_r  <= out_cnt_nxt;
      speed_r    <= speed_nxt;
      busy_r     <= busy_nxt;
      s1_vld_r   <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    s1_r   <= s1_nxt;
  end

  assign wout           = {{drsr_pkg::OUT_FRAME_BITS{1'b0}}, ram_rdata};
  assign push_vld       = s1_vld_r;
  assign push_res.desc  = s1_r;
  assign push_res.frame = s1_r.frame_valid ? wout[drsr_pkg::OUT_FRAME_BITS-1:0] : '0;

endmodule

// ===== hdl/drsr_back.sv =====
// Back end: a short queue of finished result words that drives the output channel.
// Uses drsr_pkg.
module drsr_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push_vld,
  input  drsr_pkg::res_t                      push_res,
  output logic [drsr_pkg::QCNT_BITS-1:0]      q_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [drsr_pkg::OUT_FRAME_BITS-1:0] out_frame_out,
  output logic                                out_frame_valid,
  output logic                                out_ring_empty,
  output logic                                out_last_of_period,
  output drsr_pkg::speed_t                    out_speed_code
);

  localparam int QPW = drsr_pkg::QPTR_BITS;
  localparam int QCW = drsr_pkg::QCNT_BITS;

  drsr_pkg::res_t   fifo_r [drsr_pkg::QDEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             pop;
  drsr_pkg::res_t   head;

  assign pop        = out_valid & ~out_stall;
  assign wr_ptr_nxt = push_vld ? wr_ptr_r + QPW'(1) : wr_ptr_r;
  assign rd_ptr_nxt = pop ? rd_ptr_r + QPW'(1) : rd_ptr_r;
  assign count_nxt  = count_r + QCW'(push_vld) - QCW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_vld) begin
      fifo_r[wr_ptr_r] <= push_res;
    end
  end

  assign head               = fifo_r[rd_ptr_r];
  assign q_count            = count_r;
  assign out_valid          = (count_r != '0);
  assign out_frame_out      = head.frame;
  assign out_frame_valid    = head.desc.frame_valid;
  assign out_ring_empty     = head.desc.ring_empty;
  assign out_last_of_period = head.desc.last_of_period;
  assign out_speed_code     = head.desc.speed_code;

endmodule
